// File: rtl/u8cw_pkg.sv
package u8cw_pkg;

  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int WID_W  = 2;
  localparam int LEN_W  = 3;
  localparam int RCV_W  = 2;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Sequence lengths held in the partial-sequence state.
  localparam logic [LEN_W-1:0] SEQ_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] SEQ_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] SEQ_THREE = 3'd3;
  localparam logic [LEN_W-1:0] SEQ_FOUR  = 3'd4;

  // Column widths.
  localparam logic [WID_W-1:0] COL_ZERO = 2'd0;
  localparam logic [WID_W-1:0] COL_ONE  = 2'd1;
  localparam logic [WID_W-1:0] COL_TWO  = 2'd2;

  // Job queue between the front and back halves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One classified input byte: a number of replacements, then an optional
  // final code point.
  typedef struct packed {
    logic [RCV_W-1:0] nrep;
    logic             has_tail;
    logic [CP_W-1:0]  tail_cp;
    logic             tail_repl;
    logic             eot;
  } job_t;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } span_t;

  localparam int ZW_COUNT   = 30;
  localparam int WIDE_COUNT = 20;

  localparam span_t ZW_TABLE [ZW_COUNT] = '{
    '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005BD},
    '{21'h00610, 21'h0061A}, '{21'h0064B, 21'h0065F}, '{21'h00670, 21'h00670},
    '{21'h006D6, 21'h006DC}, '{21'h00711, 21'h00711}, '{21'h00730, 21'h0074A},
    '{21'h007A6, 21'h007B0}, '{21'h00816, 21'h00819}, '{21'h0081B, 21'h00823},
    '{21'h00900, 21'h00902}, '{21'h0093C, 21'h0093C}, '{21'h00941, 21'h00948},
    '{21'h0094D, 21'h0094D}, '{21'h00951, 21'h00957}, '{21'h00E31, 21'h00E31},
    '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E}, '{21'h01AB0, 21'h01AFF},
    '{21'h01DC0, 21'h01DFF}, '{21'h0200B, 21'h0200F}, '{21'h02028, 21'h0202E},
    '{21'h02060, 21'h02064}, '{21'h020D0, 21'h020F0}, '{21'h0FE00, 21'h0FE0F},
    '{21'h0FE20, 21'h0FE2F}, '{21'h0FEFF, 21'h0FEFF}, '{21'hE0100, 21'hE01EF}
  };

  localparam span_t WIDE_TABLE [WIDE_COUNT] = '{
    '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
    '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
    '{21'h0A960, 21'h0A97F}, '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF},
    '{21'h0FE10, 21'h0FE19}, '{21'h0FE30, 21'h0FE6F}, '{21'h0FF00, 21'h0FF60},
    '{21'h0FFE0, 21'h0FFE6}, '{21'h1F300, 21'h1F5FF}, '{21'h1F600, 21'h1F64F},
    '{21'h1F680, 21'h1F6FF}, '{21'h1F900, 21'h1F9FF}, '{21'h1FA70, 21'h1FAFF},
    '{21'h20000, 21'h2FFFD}, '{21'h30000, 21'h3FFFD}
  };

  // Terminal width of a code point; only the first zw_used / wide_used
  // table entries take part. All compares run in parallel.
  function automatic logic [WID_W-1:0] col_width(input logic [CP_W-1:0] cp,
                                                 input int zw_used,
                                                 input int wide_used);
    logic zw_hit;
    logic wide_hit;
    logic ctrl;
    zw_hit   = 1'b0;
    wide_hit = 1'b0;
    ctrl     = (cp < 21'h20) || ((cp >= 21'h7F) && (cp < 21'hA0));
    for (int k = 0; k < ZW_COUNT; k++) begin
      if ((k < zw_used) && (cp >= ZW_TABLE[k].lo) && (cp <= ZW_TABLE[k].hi)) begin
        zw_hit = 1'b1;
      end
    end
    for (int k = 0; k < WIDE_COUNT; k++) begin
      if ((k < wide_used) && (cp >= WIDE_TABLE[k].lo) && (cp <= WIDE_TABLE[k].hi)) begin
        wide_hit = 1'b1;
      end
    end
    if (ctrl || zw_hit) begin
      return COL_ZERO;
    end else if (wide_hit) begin
      return COL_TWO;
    end
    return COL_ONE;
  endfunction

endpackage

// File: rtl/u8cw_if.sv
interface u8cw_in_if import u8cw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8cw_out_if import u8cw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [WID_W-1:0] column_width;
  logic             was_replaced;
  logic             last_of_run;
  logic             text_done;

  modport source (output valid, output code_point, output column_width,
                  output was_replaced, output last_of_run, output text_done,
                  input ready);
  modport sink   (input valid, input code_point, input column_width,
                  input was_replaced, input last_of_run, input text_done,
                  output ready);
endinterface

// File: rtl/utf8_decode_column_width.sv
// Each result passes through the job queue and then the output register, and waits
// there while earlier results drain.
// One byte per cycle while the queue has room; n results take n output transfers.
// Reset (rst_n, synchronous, active low) drops any open sequence, empties the job
// queue and clears the output valid; no clearing pass is needed.
module utf8_decode_column_width import u8cw_pkg::*; #(
  parameter int ZERO_WIDTH_RANGES = 30,
  parameter int WIDE_RANGES       = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  u8cw_in_if.sink    in_ch,
  u8cw_out_if.source out_ch
);

  // The front half decodes each byte against the partial-sequence state and
  // turns it into one job: a count of replacement characters to emit, then
  // an optional final code point. Bytes that only extend a sequence make no
  // job at all.
  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_empty;
  job_t q_head;

  u8cw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.text_byte),
    .in_eot   (in_ch.end_of_text),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // A four-entry queue lets the front keep taking bytes while the back
  // expands an error burst into several result transfers.
  u8cw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Unless the receiver stalls, the back half emits one result per cycle from
  // the head job, looks up the chosen code point's column width and registers it.
  u8cw_back #(
    .ZERO_WIDTH_RANGES (ZERO_WIDTH_RANGES),
    .WIDE_RANGES       (WIDE_RANGES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/u8cw_front.sv
module u8cw_front import u8cw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_eot,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_job
);

  logic [LEN_W-1:0] seq_len_r, seq_len_nxt;
  logic [RCV_W-1:0] rcvd_r, rcvd_nxt;
  logic [CP_W-1:0]  bits_r, bits_nxt;

  logic             accept;
  logic             is_cont;
  logic [RCV_W-1:0] rcvd_inc;
  logic [CP_W-1:0]  bits_shift;
  logic             seq_done;
  logic             bad_value;
  job_t             job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign rcvd_inc = rcvd_r + 2'd1;
  assign bits_shift = {bits_r[CP_W-7:0], in_byte[5:0]};
  assign seq_done = (rcvd_inc == 2'd0) || ({1'b0, rcvd_inc} >= seq_len_r);

  always_comb begin
    bad_value = 1'b0;
    if (((seq_len_r == SEQ_TWO) && (bits_shift < 21'h80)) ||
        ((seq_len_r == SEQ_THREE) && (bits_shift < 21'h800)) ||
        ((seq_len_r == SEQ_FOUR) && (bits_shift < 21'h10000))) begin
      bad_value = 1'b1;
    end
    if ((bits_shift >= 21'hD800) && (bits_shift <= 21'hDFFF)) begin
      bad_value = 1'b1;
    end
    if (bits_shift > 21'h10FFFF) begin
      bad_value = 1'b1;
    end
  end

  always_comb begin
    logic fresh;
    fresh         = 1'b0;
    seq_len_nxt   = seq_len_r;
    rcvd_nxt      = rcvd_r;
    bits_nxt      = bits_r;
    job.nrep      = 2'd0;
    job.has_tail  = 1'b0;
    job.tail_cp   = REPL_CP;
    job.tail_repl = 1'b1;
    job.eot       = in_eot;

    if (seq_len_r != SEQ_NONE) begin
      if (is_cont) begin
        if (seq_done) begin
          job.has_tail  = 1'b1;
          job.tail_cp   = bad_value ? REPL_CP : bits_shift;
          job.tail_repl = bad_value;
          seq_len_nxt   = SEQ_NONE;
          rcvd_nxt      = 2'd0;
          bits_nxt      = '0;
        end else if (in_eot) begin
          job.nrep    = rcvd_inc;
          seq_len_nxt = SEQ_NONE;
          rcvd_nxt    = 2'd0;
          bits_nxt    = '0;
        end else begin
          rcvd_nxt = rcvd_inc;
          bits_nxt = bits_shift;
        end
      end else begin
        // Broken sequence: flush what was buffered, then take the byte anew.
        job.nrep    = rcvd_r;
        seq_len_nxt = SEQ_NONE;
        rcvd_nxt    = 2'd0;
        bits_nxt    = '0;
        fresh       = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      priority if (!in_byte[7]) begin
        job.has_tail  = 1'b1;
        job.tail_cp   = {13'd0, in_byte};
        job.tail_repl = 1'b0;
      end else if ((in_byte[7:5] == 3'b110) || (in_byte[7:4] == 4'b1110) ||
                   (in_byte[7:3] == 5'b11110)) begin
        if (in_eot) begin
          job.has_tail = 1'b1;
        end else begin
          rcvd_nxt = 2'd1;
          priority if (in_byte[7:5] == 3'b110) begin
            seq_len_nxt = SEQ_TWO;
            bits_nxt    = {16'd0, in_byte[4:0]};
          end else if (in_byte[7:4] == 4'b1110) begin
            seq_len_nxt = SEQ_THREE;
            bits_nxt    = {17'd0, in_byte[3:0]};
          end else begin
            seq_len_nxt = SEQ_FOUR;
            bits_nxt    = {18'd0, in_byte[2:0]};
          end
        end
      end else begin
        // Invalid lead or stray continuation.
        job.has_tail = 1'b1;
      end
    end
  end

  assign q_push = accept && ((job.nrep != 2'd0) || job.has_tail);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= SEQ_NONE;
      rcvd_r    <= 2'd0;
      bits_r    <= '0;
    end else if (accept) begin
      seq_len_r <= seq_len_nxt;
      rcvd_r    <= rcvd_nxt;
      bits_r    <= bits_nxt;
    end
  end

endmodule

// File: rtl/u8cw_queue.sv
module u8cw_queue import u8cw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/u8cw_back.sv
module u8cw_back import u8cw_pkg::*; #(
  parameter int ZERO_WIDTH_RANGES = 30,
  parameter int WIDE_RANGES       = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        q_pop,
  u8cw_out_if.source  out_ch
);

  logic [RCV_W-1:0] rep_idx_r;
  logic             out_valid_r;
  logic [CP_W-1:0]  cp_r;
  logic [WID_W-1:0] width_r;
  logic             repl_r;
  logic             last_r;
  logic             done_r;

  logic             load;
  logic             is_rep;
  logic             is_last;
  logic [CP_W-1:0]  cp_sel;
  logic             repl_sel;

  assign load   = !q_empty && (!out_valid_r || out_ch.ready);
  assign is_rep = (rep_idx_r < q_head.nrep);

  always_comb begin
    if (is_rep) begin
      cp_sel   = REPL_CP;
      repl_sel = 1'b1;
      is_last  = (rep_idx_r == (q_head.nrep - 2'd1)) && !q_head.has_tail;
    end else begin
      cp_sel   = q_head.tail_cp;
      repl_sel = q_head.tail_repl;
      is_last  = 1'b1;
    end
  end

  assign q_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        rep_idx_r   <= is_last ? '0 : rep_idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r    <= cp_sel;
      width_r <= col_width(cp_sel, ZERO_WIDTH_RANGES, WIDE_RANGES);
      repl_r  <= repl_sel;
      last_r  <= is_last;
      done_r  <= is_last && q_head.eot;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = cp_r;
  assign out_ch.column_width = width_r;
  assign out_ch.was_replaced = repl_r;
  assign out_ch.last_of_run  = last_r;
  assign out_ch.text_done    = done_r;

endmodule

// File: test/utf8_decode_column_width_test.sv
`timescale 1ns / 100ps

module utf8_decode_column_width_test;
  import u8cw_pkg::*;

  localparam int ZERO_WIDTH_RANGES = 30;
  localparam int WIDE_RANGES       = 20;
  localparam int RANDOM_PER_PHASE  = 62;
  // A correct block never goes this long without a transfer on either side,
  // even with the receiver stalling 74 percent of the time.
  localparam int QUIET_LIMIT       = 2000;
  localparam int DRAIN_CYCLES      = 16;
  localparam int SCRIPT_ROWS       = 23;

  // One decoded character as it leaves the block.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [WID_W-1:0] column_width;
    logic             was_replaced;
    logic             last_of_run;
    logic             text_done;
  } glyph_t;

  // One row of the directed script. When spelled is set, the byte is known to
  // give exactly one character, and that character is written out in the row.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
    logic              spelled;
    logic [CP_W-1:0]   code_point;
    logic [WID_W-1:0]  column_width;
    logic              was_replaced;
  } script_row_t;

  // Terminal width tables, each entry {first, last} code point.
  localparam logic [2*CP_W-1:0] ZW_SPANS [ZERO_WIDTH_RANGES] = '{
    {21'h00300, 21'h0036F}, {21'h00483, 21'h00489}, {21'h00591, 21'h005BD},
    {21'h00610, 21'h0061A}, {21'h0064B, 21'h0065F}, {21'h00670, 21'h00670},
    {21'h006D6, 21'h006DC}, {21'h00711, 21'h00711}, {21'h00730, 21'h0074A},
    {21'h007A6, 21'h007B0}, {21'h00816, 21'h00819}, {21'h0081B, 21'h00823},
    {21'h00900, 21'h00902}, {21'h0093C, 21'h0093C}, {21'h00941, 21'h00948},
    {21'h0094D, 21'h0094D}, {21'h00951, 21'h00957}, {21'h00E31, 21'h00E31},
    {21'h00E34, 21'h00E3A}, {21'h00E47, 21'h00E4E}, {21'h01AB0, 21'h01AFF},
    {21'h01DC0, 21'h01DFF}, {21'h0200B, 21'h0200F}, {21'h02028, 21'h0202E},
    {21'h02060, 21'h02064}, {21'h020D0, 21'h020F0}, {21'h0FE00, 21'h0FE0F},
    {21'h0FE20, 21'h0FE2F}, {21'h0FEFF, 21'h0FEFF}, {21'hE0100, 21'hE01EF}
  };

  localparam logic [2*CP_W-1:0] WIDE_SPANS [WIDE_RANGES] = '{
    {21'h01100, 21'h0115F}, {21'h02E80, 21'h0303E}, {21'h03041, 21'h033FF},
    {21'h03400, 21'h04DBF}, {21'h04E00, 21'h09FFF}, {21'h0A000, 21'h0A4CF},
    {21'h0A960, 21'h0A97F}, {21'h0AC00, 21'h0D7A3}, {21'h0F900, 21'h0FAFF},
    {21'h0FE10, 21'h0FE19}, {21'h0FE30, 21'h0FE6F}, {21'h0FF00, 21'h0FF60},
    {21'h0FFE0, 21'h0FFE6}, {21'h1F300, 21'h1F5FF}, {21'h1F600, 21'h1F64F},
    {21'h1F680, 21'h1F6FF}, {21'h1F900, 21'h1F9FF}, {21'h1FA70, 21'h1FAFF},
    {21'h20000, 21'h2FFFD}, {21'h30000, 21'h3FFFD}
  };

  // The directed script: plain ASCII at both ends of the control range, an
  // invalid lead, a stray continuation, a control character reached through a
  // two-byte sequence, the highest scalar value, an overlong form, a four-byte
  // sequence broken by an invalid lead (four replacements from one byte), a
  // text that ends inside a sequence, a text that ends on a lead, a fresh text
  // after that, and an encoded surrogate.
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 21'h00000, COL_ZERO, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h0007F, COL_ZERO, 1'b0},
    '{8'hFF, 1'b0, 1'b1, REPL_CP,   COL_ONE,  1'b1},
    '{8'h80, 1'b0, 1'b1, REPL_CP,   COL_ONE,  1'b1},
    '{8'hC2, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'h85, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hC0, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hAF, 1'b0, 1'b1, REPL_CP,   COL_ONE,  1'b1},
    '{8'hF0, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'h98, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hE4, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hB8, 1'b1, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hC3, 1'b1, 1'b1, REPL_CP,   COL_ONE,  1'b1},
    '{8'h41, 1'b0, 1'b1, 21'h00041, COL_ONE,  1'b0},
    '{8'hED, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 21'h0,     COL_ZERO, 1'b0},
    '{8'h80, 1'b0, 1'b1, REPL_CP,   COL_ONE,  1'b1}
  };

  logic clk;
  logic rst_n;

  u8cw_in_if  in_bus ();
  u8cw_out_if out_bus ();

  utf8_decode_column_width #(
    .ZERO_WIDTH_RANGES(ZERO_WIDTH_RANGES),
    .WIDE_RANGES      (WIDE_RANGES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Decoder state as the block should hold it after each accepted byte.
  logic [CP_W-1:0]  gathered_bits;
  logic [LEN_W-1:0] open_length;
  logic [RCV_W-1:0] taken_count;

  glyph_t glyphs_due[$];    // Characters still owed by the block, oldest first.
  glyph_t byte_glyphs[$];   // Characters caused by the byte being decoded.
  logic [BYTE_W-1:0] burst[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int faults;
  int bytes_fed;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character decoding, kept in step with every accepted byte.
  // ---------------------------------------------------------------------------

  // Controls and zero-width marks take no column; the wide spans take two.
  function automatic logic [WID_W-1:0] columns_for(input logic [CP_W-1:0] cp);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      return COL_ZERO;
    end
    for (int k = 0; k < ZERO_WIDTH_RANGES; k++) begin
      if (cp >= ZW_SPANS[k][2*CP_W-1:CP_W] && cp <= ZW_SPANS[k][CP_W-1:0]) begin
        return COL_ZERO;
      end
    end
    for (int k = 0; k < WIDE_RANGES; k++) begin
      if (cp >= WIDE_SPANS[k][2*CP_W-1:CP_W] && cp <= WIDE_SPANS[k][CP_W-1:0]) begin
        return COL_TWO;
      end
    end
    return COL_ONE;
  endfunction

  // Adds a character to the end of the list the block still owes.
  function automatic void owe_glyph(input glyph_t g);
    glyphs_due.insert(glyphs_due.size(), g);
  endfunction

  // Adds a byte to the end of the piece of text being built.
  function automatic void put_byte(input logic [BYTE_W-1:0] b);
    burst.insert(burst.size(), b);
  endfunction

  // No byte can owe more than four characters; anything beyond is dropped.
  function automatic void emit_glyph(input logic [CP_W-1:0] cp, input logic replaced);
    glyph_t g;
    g.code_point   = cp;
    g.column_width = columns_for(cp);
    g.was_replaced = replaced;
    g.last_of_run  = 1'b0;
    g.text_done    = 1'b0;
    if (byte_glyphs.size() < 4) begin
      byte_glyphs.insert(byte_glyphs.size(), g);
    end
  endfunction

  function automatic void clear_sequence();
    gathered_bits = '0;
    open_length   = SEQ_NONE;
    taken_count   = '0;
  endfunction

  // A sequence that cannot complete costs one replacement per byte taken.
  function automatic void abandon_sequence(input logic [RCV_W-1:0] bytes_held);
    for (int k = 0; k < bytes_held; k++) begin
      emit_glyph(REPL_CP, 1'b1);
    end
    clear_sequence();
  endfunction

  // Handles a byte with no sequence open: ASCII, a lead, or garbage.
  function automatic void start_character(input logic [BYTE_W-1:0] b, input logic eot);
    logic [LEN_W-1:0] need;
    logic [CP_W-1:0]  payload;
    if (b < 8'h80) begin
      emit_glyph(CP_W'(b), 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) begin
      need    = SEQ_TWO;
      payload = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      need    = SEQ_THREE;
      payload = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      need    = SEQ_FOUR;
      payload = CP_W'(b[2:0]);
    end else begin
      emit_glyph(REPL_CP, 1'b1);
      return;
    end
    // A lead as the very last byte of the text is already truncated.
    if (eot) begin
      emit_glyph(REPL_CP, 1'b1);
      return;
    end
    gathered_bits = payload;
    open_length   = need;
    taken_count   = 2'd1;
  endfunction

  // Overlong forms, surrogates and values past the last plane are rejected.
  function automatic void complete_sequence();
    logic bad;
    bad = (open_length == SEQ_TWO   && gathered_bits < 21'h80)   ||
          (open_length == SEQ_THREE && gathered_bits < 21'h800)  ||
          (open_length == SEQ_FOUR  && gathered_bits < 21'h10000) ||
          (gathered_bits >= 21'hD800 && gathered_bits <= 21'hDFFF) ||
          (gathered_bits > 21'h10FFFF);
    if (bad) begin
      emit_glyph(REPL_CP, 1'b1);
    end else begin
      emit_glyph(gathered_bits, 1'b0);
    end
    clear_sequence();
  endfunction

  // Works out every character that one byte causes, into byte_glyphs.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
    byte_glyphs.delete();
    if (open_length != SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        gathered_bits = {gathered_bits[CP_W-7:0], b[5:0]};
        taken_count   = taken_count + 2'd1;
        // The two-bit count wraps to zero on the fourth byte of a sequence.
        if (taken_count == 2'd0 || LEN_W'(taken_count) >= open_length) begin
          complete_sequence();
        end else if (eot) begin
          abandon_sequence(taken_count);
        end
      end else begin
        // The breaking byte is replayed as the start of something new.
        abandon_sequence(taken_count);
        start_character(b, eot);
      end
    end else begin
      start_character(b, eot);
    end
    if (byte_glyphs.size() > 0) begin
      byte_glyphs[byte_glyphs.size()-1].last_of_run = 1'b1;
      byte_glyphs[byte_glyphs.size()-1].text_done   = eot;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte source.
  // ---------------------------------------------------------------------------

  // Offers one byte, holding it until the transfer, then records what it owes.
  // Entered and left right after a rising edge, so valid gets one update per
  // edge: lowered for an idle cycle, or raised with the new byte.
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic eot,
                           input logic spelled, input glyph_t spelled_glyph);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.text_byte   <= b;
    in_bus.end_of_text <= eot;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    decode_byte(b, eot);
    if (spelled) begin
      owe_glyph(spelled_glyph);
    end else begin
      foreach (byte_glyphs[k]) begin
        owe_glyph(byte_glyphs[k]);
      end
    end
    bytes_fed++;
  endtask

  function automatic int shortest_length(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Appends the UTF-8 form of cp in exactly len bytes, overlong or not.
  function automatic void append_encoding(input logic [CP_W-1:0] cp, input int len);
    case (len)
      1: begin
        put_byte({1'b0, cp[6:0]});
      end
      2: begin
        put_byte({3'b110, cp[10:6]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
      end
    endcase
    if (len > 1) begin
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  // A multi-byte code point, picked at random by length (surrogates included).
  function automatic logic [CP_W-1:0] any_multibyte();
    case ($urandom_range(2))
      0: return CP_W'($urandom_range(21'h7FF, 21'h80));
      1: return CP_W'($urandom_range(21'hFFFF, 21'h800));
      default: return CP_W'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
  endfunction

  // Builds the next piece of text in burst. Most pieces are whole characters,
  // many drawn from inside the width spans; the rest are overlong forms,
  // out-of-range values, surrogates, sequences cut short and bare noise bytes.
  function automatic void next_piece();
    int pick;
    int len;
    logic [CP_W-1:0] cp;
    logic [2*CP_W-1:0] span;
    burst.delete();
    pick = $urandom_range(99);
    if (pick < 25) begin
      put_byte(BYTE_W'($urandom_range(127)));
    end else if (pick < 70) begin
      if ($urandom_range(1) == 1) begin
        span = ($urandom_range(1) == 1) ? ZW_SPANS[$urandom_range(ZERO_WIDTH_RANGES-1)]
                                        : WIDE_SPANS[$urandom_range(WIDE_RANGES-1)];
        cp = span[2*CP_W-1:CP_W] +
             CP_W'($urandom_range(span[CP_W-1:0] - span[2*CP_W-1:CP_W]));
      end else begin
        cp = any_multibyte();
      end
      append_encoding(cp, shortest_length(cp));
    end else if (pick < 78) begin
      cp = CP_W'($urandom_range(16'hFFFF));
      append_encoding(cp, $urandom_range(4, shortest_length(cp) + 1));
    end else if (pick < 84) begin
      if ($urandom_range(1) == 1) begin
        append_encoding(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      end else begin
        append_encoding(CP_W'($urandom_range(16'hDFFF, 16'hD800)), 3);
      end
    end else if (pick < 92) begin
      cp  = any_multibyte();
      len = shortest_length(cp);
      append_encoding(cp, len);
      repeat ($urandom_range(len - 1, 1)) void'(burst.pop_back());
    end else begin
      put_byte(BYTE_W'($urandom_range(255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure and checking against the oldest debt.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (glyphs_due.size() == 0) begin
        $error("code_point: expected nothing, got 0x%0h", out_bus.code_point);
        faults++;
      end else begin
        want = glyphs_due.pop_front();
        compare_field("code_point",   want.code_point,   out_bus.code_point);
        compare_field("column_width", want.column_width, out_bus.column_width);
        compare_field("was_replaced", want.was_replaced, out_bus.was_replaced);
        compare_field("last_of_run",  want.last_of_run,  out_bus.last_of_run);
        compare_field("text_done",    want.text_done,    out_bus.text_done);
      end
    end
  end

  // Watchdog: a stretch with no transfer on either side means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("utf8_decode_column_width_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    int goal;
    glyph_t spelled_glyph;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.text_byte   = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready      = 1'b0;
    faults             = 0;
    bytes_fed          = 0;
    quiet_cycles       = 0;
    tx_idle_pct        = 21;
    rx_idle_pct        = 74;
    clear_sequence();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script, run under the first idling mix.
    foreach (script[r]) begin
      spelled_glyph = '{script[r].code_point, script[r].column_width,
                        script[r].was_replaced, 1'b1, script[r].end_of_text};
      feed_byte(script[r].text_byte, script[r].end_of_text, script[r].spelled,
                spelled_glyph);
    end

    // Random text in three idling mixes: a slow receiver, then a slow sender,
    // then both at full rate. An end of text falls now and then at the end of
    // a piece, and more rarely in the middle of one.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 74 : 0;
      rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 21 : 0;
      goal = bytes_fed + RANDOM_PER_PHASE;
      while (bytes_fed < goal) begin
        next_piece();
        foreach (burst[k]) begin
          feed_byte(burst[k],
                    ($urandom_range(29) == 0) ||
                    (k == burst.size() - 1 && $urandom_range(9) == 0),
                    1'b0, '0);
        end
      end
    end
    in_bus.valid <= 1'b0;

    while (glyphs_due.size() != 0) @(posedge clk);
    // Give a block that emits too much the chance to show it.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (faults == 0 && glyphs_due.size() == 0) begin
      $display("utf8_decode_column_width_test passed");
    end else begin
      $display("utf8_decode_column_width_test failed");
    end
    $finish;
  end

endmodule
